FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/iee_pkg.sv
// Types and constants of the expression evaluator.
package iee_pkg;
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_item_t;

  // token classes from the front end
  localparam logic [2:0] TK_DIGIT = 3'd0;
  localparam logic [2:0] TK_LPAR  = 3'd1;
  localparam logic [2:0] TK_RPAR  = 3'd2;
  localparam logic [2:0] TK_OP    = 3'd3;
  localparam logic [2:0] TK_NONE  = 3'd4;

  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_LPAR = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] op;
    logic [3:0] digit;
    logic       last;
  } token_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    case (op)
      OP_ADD, OP_SUB: prec = 2'd1;
      OP_MUL, OP_DIV: prec = 2'd2;
      default:        prec = 2'd0;
    endcase
  endfunction
endpackage

FILE: rtl/iee_front.sv
// Front end: classifies characters into tokens and queues them.
module iee_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  iee_pkg::in_item_t data,
  output logic              tok_valid,
  input  logic              tok_take,
  output iee_pkg::token_t   tok
);
  iee_pkg::token_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  iee_pkg::token_t t;
  logic push, pop;

  always_comb begin
    t.last = data.last;
    t.digit = data.ch[3:0];
    t.op = iee_pkg::OP_ADD;
    t.kind = iee_pkg::TK_NONE;
    case (data.ch)
      8'h28: t.kind = iee_pkg::TK_LPAR;
      8'h29: t.kind = iee_pkg::TK_RPAR;
      8'h2b: t.kind = iee_pkg::TK_OP;
      8'h2d: begin t.kind = iee_pkg::TK_OP; t.op = iee_pkg::OP_SUB; end
      8'h2a: begin t.kind = iee_pkg::TK_OP; t.op = iee_pkg::OP_MUL; end
      8'h2f: begin t.kind = iee_pkg::TK_OP; t.op = iee_pkg::OP_DIV; end
      default: if (data.ch >= 8'h30 && data.ch <= 8'h39) t.kind = iee_pkg::TK_DIGIT;
    endcase
  end

  assign stall = cnt[2];
  assign push = valid && !stall;
  assign tok_valid = cnt != 3'd0;
  assign pop = tok_valid && tok_take;
  assign tok = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
    if (push) q[wp] <= t;
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_no_overfill, clk, rst, cnt > 3'd4, "token queue overfilled")
  `ASSERT_CLK(a_cnt_track, clk, rst, (push && !pop) |=> cnt == $past(cnt) + 3'd1, "count slip")
  `ASSERT_CLK(a_pop_nonempty, clk, rst, pop |-> cnt != 3'd0, "pop of empty queue")
endmodule

FILE: rtl/iee_divider.sv
// Iterative 64-bit signed divider, one quotient bit per cycle.
module iee_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] q
);
  logic [63:0] ma, mb, rem, quo;
  logic neg, busy;
  logic [6:0] n;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n <= 7'd64;
        ma <= a[63] ? 64'd0 - a : a;
        mb <= b[63] ? 64'd0 - b : b;
        neg <= a[63] ^ b[63];
        rem <= '0;
        quo <= a[63] ? 64'd0 - a : a;
      end else if (busy) begin
        if (!trial[64]) rem <= trial[63:0];
        else rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], !trial[64]};
        n <= n - 7'd1;
        if (n == 7'd1) begin busy <= 1'b0; done <= 1'b1; end
      end
    end
  end
  assign q = neg ? 64'd0 - quo : quo;
  logic unused;
  assign unused = ^ma;
endmodule

FILE: rtl/iee_back.sv
// Back end: operator and value stacks with reduction sequencer.
module iee_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_take,
  input  iee_pkg::token_t    tok,
  output logic               out_valid,
  input  logic               out_stall,
  output iee_pkg::out_item_t out_data
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_OPRD = 4'd1, S_VRD1 = 4'd2, S_VRD2 = 4'd3,
                         S_EXEC = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_WB = 4'd7,
                         S_DECIDE = 4'd8, S_OUT = 4'd9, S_FRD = 4'd10;

  // internal token kind: expression end, after the last request's own token
  localparam logic [2:0] TK_FIN = 3'd5;

  logic [2:0]  ops [STACK_DEPTH];
  logic [63:0] vals [STACK_DEPTH];
  logic [CW-1:0] opc, valc;
  logic [63:0] acc, a, b, r;
  logic nopen, after, is_last;
  logic [1:0] err;
  logic [3:0] st;
  iee_pkg::token_t cur;
  logic [2:0] tok_kind;
  logic [2:0] top_op, rd_op;
  logic [63:0] rd_val;
  logic [63:0] res_value;
  logic div_start, div_done;
  logic [63:0] div_q;
  logic [63:0] ml, mh, m_cross;
  logic [1:0] mstep;

  iee_divider u_div (.clk, .rst, .start(div_start), .a, .b, .done(div_done), .q(div_q));

  assign tok_take = (st == S_IDLE) && tok_valid;
  assign out_valid = st == S_OUT;

  // only ')' and operators need work past the take cycle
  assign tok_kind = (tok.kind == iee_pkg::TK_RPAR || tok.kind == iee_pkg::TK_OP) ?
                    tok.kind : iee_pkg::TK_NONE;

  assign div_start = (st == S_EXEC) && (rd_op != iee_pkg::OP_ADD) &&
                     (rd_op != iee_pkg::OP_SUB) && (rd_op != iee_pkg::OP_MUL) &&
                     (b != 64'd0);

  function automatic logic [1:0] first_err(input logic [1:0] e, input logic [1:0] n);
    first_err = (e != iee_pkg::ST_OK) ? e : n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; opc <= '0; valc <= '0; acc <= '0; nopen <= 1'b0;
      after <= 1'b0; err <= iee_pkg::ST_OK; is_last <= 1'b0;
    end else begin
      case (st)
        S_IDLE: if (tok_valid) begin
          cur <= '{kind: tok_kind, op: tok.op, digit: tok.digit, last: tok.last};
          is_last <= tok.last;
          st <= S_DECIDE;
          if (err == iee_pkg::ST_OK) begin
            case (tok.kind)
              iee_pkg::TK_DIGIT: begin
                if (!nopen && after) err <= iee_pkg::ST_BAD;
                else begin
                  acc <= (nopen ? {acc[60:0], 3'b0} + {acc[62:0], 1'b0} : 64'd0)
                         + {60'd0, tok.digit};
                  nopen <= 1'b1; after <= 1'b1;
                end
              end
              iee_pkg::TK_LPAR: begin
                if (after) err <= iee_pkg::ST_BAD;
                else if (opc == FULL) err <= iee_pkg::ST_OVF;
                else begin ops[opc[AW-1:0]] <= iee_pkg::OP_LPAR; opc <= opc + CW'(1); end
              end
              iee_pkg::TK_RPAR, iee_pkg::TK_OP: begin
                if (nopen) begin
                  nopen <= 1'b0; acc <= '0;
                  if (valc == FULL) err <= iee_pkg::ST_OVF;
                  else begin vals[valc[AW-1:0]] <= acc; valc <= valc + CW'(1); end
                end else if (!after) err <= iee_pkg::ST_BAD;
              end
              default: ;
            endcase
          end
        end
        S_DECIDE: begin
          // cur.kind TK_NONE means the token is done; then finish if last
          if (err != iee_pkg::ST_OK) begin
            cur.kind <= iee_pkg::TK_NONE;
            st <= is_last ? S_FRD : S_IDLE;
          end else begin
            case (cur.kind)
              iee_pkg::TK_OP: begin
                if (opc != '0 && top_op != iee_pkg::OP_LPAR &&
                    iee_pkg::prec(top_op) >= iee_pkg::prec(cur.op)) st <= S_OPRD;
                else begin
                  if (opc == FULL) err <= iee_pkg::ST_OVF;
                  else begin ops[opc[AW-1:0]] <= cur.op; opc <= opc + CW'(1); end
                  after <= 1'b0;
                  cur.kind <= iee_pkg::TK_NONE;
                end
              end
              iee_pkg::TK_RPAR: begin
                if (opc == '0) begin err <= iee_pkg::ST_BAD; cur.kind <= iee_pkg::TK_NONE; end
                else if (top_op != iee_pkg::OP_LPAR) st <= S_OPRD;
                else begin opc <= opc - CW'(1); cur.kind <= iee_pkg::TK_NONE; end
              end
              iee_pkg::TK_NONE: begin
                if (!is_last) st <= S_IDLE;
                else begin
                  cur.kind <= TK_FIN;
                  if (nopen) begin
                    nopen <= 1'b0;
                    if (valc == FULL) err <= iee_pkg::ST_OVF;
                    else begin vals[valc[AW-1:0]] <= acc; valc <= valc + CW'(1); end
                  end else if (!after) err <= iee_pkg::ST_BAD;
                end
              end
              default: begin // finishing
                if (opc == '0) begin
                  if (valc != CW'(1)) err <= iee_pkg::ST_BAD;
                  st <= S_FRD;
                end else if (top_op == iee_pkg::OP_LPAR) err <= iee_pkg::ST_BAD;
                else st <= S_OPRD;
              end
            endcase
          end
        end
        S_OPRD: begin
          rd_op <= top_op;
          opc <= opc - CW'(1);
          if (valc < CW'(2)) begin err <= iee_pkg::ST_BAD; st <= S_DECIDE; end
          else begin valc <= valc - CW'(1); st <= S_VRD1; end
        end
        // the read port is registered from the count: b is read in S_OPRD, a in S_VRD1
        S_VRD1: begin b <= rd_val; valc <= valc - CW'(1); st <= S_VRD2; end
        S_VRD2: begin a <= rd_val; st <= S_EXEC; end
        S_EXEC: begin
          case (rd_op)
            iee_pkg::OP_ADD: begin r <= a + b; st <= S_WB; end
            iee_pkg::OP_SUB: begin r <= a - b; st <= S_WB; end
            iee_pkg::OP_MUL: begin mstep <= 2'd0; st <= S_MUL; end
            default: begin
              if (b == 64'd0) begin err <= iee_pkg::ST_DIV0; st <= S_DECIDE; end
              else st <= S_DIV;
            end
          endcase
        end
        S_MUL: begin
          // low product from three 32x32 partials, made in mstep 0 to 2 and summed in mstep 3
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: ml <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            2'd1: mh <= {32'd0, a[31:0] * b[63:32]};
            2'd2: m_cross <= {32'd0, a[63:32] * b[31:0]};
            default: begin
              r <= ml + {mh[31:0] + m_cross[31:0], 32'd0};
              st <= S_WB;
            end
          endcase
        end
        S_DIV: if (div_done) begin r <= div_q; st <= S_WB; end
        S_WB: begin
          vals[valc[AW-1:0]] <= r; valc <= valc + CW'(1); st <= S_DECIDE;
        end
        S_FRD: st <= S_OUT;
        S_OUT: if (!out_stall) begin
          st <= S_IDLE; opc <= '0; valc <= '0; acc <= '0; nopen <= 1'b0;
          after <= 1'b0; err <= iee_pkg::ST_OK;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // synchronous stack reads
  always_ff @(posedge clk) begin
    top_op <= ops[opc[AW-1:0] - AW'(1)];
    rd_val <= vals[valc[AW-1:0] - AW'(1)];
    if (st == S_FRD) res_value <= (err == iee_pkg::ST_OK) ? vals[0] : 64'd0;
  end
  assign out_data = {res_value, err};

  logic unused;
  assign unused = ^{first_err(err, err), cur.digit, cur.last, mh[63:32], m_cross[63:32]};

`include "assert_macros.svh"
  `ASSERT_NEVER(a_op_bound, clk, rst, opc > FULL, "operator stack count out of range")
  `ASSERT_NEVER(a_val_bound, clk, rst, valc > FULL, "value stack count out of range")
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid,
              "result dropped under stall")
endmodule

FILE: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator.
// Usage:
//  Input channel in_valid/in_stall carries one character (ch) and a last flag per
//  request. Output channel out_valid/out_stall carries one result per expression,
//  issued on the request whose last flag is set.
//  The front end classifies characters into a four-entry token queue; the back
//  end runs the operator and value stacks one token at a time.
//  A digit, '(' or ignored character passes through S_DECIDE back to S_IDLE; an
//  operator or ')' first runs its reductions. Each reduction steps through S_OPRD,
//  S_VRD1, S_VRD2, S_EXEC and S_WB, with S_MUL for * and S_DIV for / before S_WB
//  (one quotient bit per cycle in the divider). On the last request the back end
//  finishes pending reductions, then passes S_FRD and raises out_valid in S_OUT.
//  Reset clears both stack counts and the queue; stacks hold no valid data
//  until pushed. While out_stall is high the result holds and the back end
//  waits; the token queue keeps accepting until its four entries are full.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  iee_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iee_pkg::out_item_t out_data
);
  logic tok_valid, tok_take;
  iee_pkg::token_t tok;

  iee_front u_front (.clk, .rst, .valid(in_valid), .stall(in_stall), .data(in_data),
                     .tok_valid, .tok_take, .tok);
  iee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (.clk, .rst, .tok_valid, .tok_take, .tok,
                     .out_valid, .out_stall, .out_data);
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the infix expression evaluator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  iee_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  iee_pkg::out_item_t out_data;

  infix_expression_evaluator #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // evaluator state mirrored by the predictor
  logic [2:0]  ops [DEPTH];
  int          n_ops;
  logic [63:0] vals [DEPTH];
  int          n_vals;
  logic [63:0] lit;
  bit          lit_open;
  logic [1:0]  err;
  bit          had_value;

  iee_pkg::in_item_t  char_queue[$];
  iee_pkg::out_item_t result_queue[$];
  int errors = 0;
  int n_results = 0;
  int n_chars = 0;
  int status_seen [4];
  bit calm = 1'b0;
  bit feed_done = 1'b0;
  longint cycles = 0;

  function automatic void clear_state();
    n_ops = 0; n_vals = 0; lit = '0; lit_open = 0; err = iee_pkg::ST_OK; had_value = 0;
  endfunction

  function automatic void flag(logic [1:0] e);
    if (err == iee_pkg::ST_OK) err = e;
  endfunction

  function automatic int rank(logic [2:0] op);
    if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
    if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
    return 0;
  endfunction

  function automatic void push_value(logic [63:0] v);
    if (n_vals >= DEPTH) flag(iee_pkg::ST_OVF);
    else begin vals[n_vals] = v; n_vals++; end
  endfunction

  function automatic void push_oper(logic [2:0] op);
    if (n_ops >= DEPTH) flag(iee_pkg::ST_OVF);
    else begin ops[n_ops] = op; n_ops++; end
  endfunction

  function automatic void apply_top();
    logic [2:0] op;
    logic [63:0] a, b, r, ma, mb, q;
    n_ops--;
    op = ops[n_ops];
    if (n_vals < 2) begin flag(iee_pkg::ST_BAD); return; end
    n_vals--; b = vals[n_vals];
    n_vals--; a = vals[n_vals];
    case (op)
      iee_pkg::OP_ADD: r = a + b;
      iee_pkg::OP_SUB: r = a - b;
      iee_pkg::OP_MUL: r = a * b;
      default: begin
        if (b == 0) begin flag(iee_pkg::ST_DIV0); return; end
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = (a[63] != b[63]) ? -q : q;
      end
    endcase
    vals[n_vals] = r; n_vals++;
  endfunction

  function automatic void close_literal();
    if (lit_open) begin push_value(lit); lit_open = 0; lit = '0; end
  endfunction

  function automatic void eval_char(logic [7:0] c);
    logic [2:0] op;
    if (c >= "0" && c <= "9") begin
      if (!lit_open) begin
        if (had_value) begin flag(iee_pkg::ST_BAD); return; end
        lit_open = 1; lit = '0;
      end
      lit = lit * 10 + 64'(c - "0");
      had_value = 1;
    end else if (c == "(") begin
      if (had_value) begin flag(iee_pkg::ST_BAD); return; end
      push_oper(iee_pkg::OP_LPAR);
    end else if (c == ")") begin
      close_literal();
      if (!had_value) begin flag(iee_pkg::ST_BAD); return; end
      while (err == iee_pkg::ST_OK && n_ops > 0 && ops[n_ops-1] != iee_pkg::OP_LPAR)
        apply_top();
      if (err != iee_pkg::ST_OK) return;
      if (n_ops == 0) begin flag(iee_pkg::ST_BAD); return; end
      n_ops--;
    end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
      op = (c == "+") ? iee_pkg::OP_ADD : (c == "-") ? iee_pkg::OP_SUB :
           (c == "*") ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
      close_literal();
      if (!had_value) begin flag(iee_pkg::ST_BAD); return; end
      while (err == iee_pkg::ST_OK && n_ops > 0 && ops[n_ops-1] != iee_pkg::OP_LPAR
             && rank(ops[n_ops-1]) >= rank(op)) apply_top();
      if (err != iee_pkg::ST_OK) return;
      push_oper(op);
      had_value = 0;
    end
  endfunction

  // returns 1 with the expected result when the character ends an expression
  function automatic bit predict_char(iee_pkg::in_item_t it, output iee_pkg::out_item_t res);
    if (err == iee_pkg::ST_OK) eval_char(it.ch);
    if (!it.last) return 0;
    close_literal();
    if (err == iee_pkg::ST_OK) begin
      if (!had_value) flag(iee_pkg::ST_BAD);
      while (err == iee_pkg::ST_OK && n_ops > 0) begin
        if (ops[n_ops-1] == iee_pkg::OP_LPAR) flag(iee_pkg::ST_BAD);
        else apply_top();
      end
      if (err == iee_pkg::ST_OK && n_vals != 1) flag(iee_pkg::ST_BAD);
    end
    res.value = (err == iee_pkg::ST_OK) ? vals[0] : '0;
    res.status = err;
    clear_state();
    return 1;
  endfunction

  task automatic add_expr(string s);
    iee_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.last = (i == s.len() - 1);
      char_queue.push_back(it);
    end
  endtask

  function automatic string rand_number();
    string s = "";
    int n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_operand(int lvl);
    if (lvl > 0 && $urandom_range(0, 3) == 0)
      return {"(", rand_expr(lvl - 1), ")"};
    return rand_number();
  endfunction

  function automatic string rand_expr(int lvl);
    string opchars = "+-*/";
    string s = rand_operand(lvl);
    int n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      s = {s, string'(opchars[$urandom_range(0, 3)])};
      if ($urandom_range(0, 9) == 0) s = {s, " "};
      s = {s, rand_operand(lvl)};
    end
    return s;
  endfunction

  function automatic string mangle(string s);
    string noise = "()+-*/0123456789 x";
    int k = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: s[k] = noise[$urandom_range(0, noise.len() - 1)];
      1: s = s.substr(0, k);
      default: s = {s, string'(noise[$urandom_range(0, 5)])};
    endcase
    return s;
  endfunction

  // stall as seen at the last rising edge, tells the driver whether the request moved
  logic in_stall_q = 1'b1;

  // driver: falling-edge launch, next request only once the current one is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          in_data <= char_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_data <= char_queue.pop_front();
        in_valid <= 1'b1;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    iee_pkg::out_item_t res;
    iee_pkg::out_item_t want;
    cycles++;
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall) begin
      n_chars++;
      if (predict_char(in_data, res)) result_queue.push_back(res);
    end
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      status_seen[out_data.status]++;
      if (result_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d status=%0d", $time,
                 out_data.value, out_data.status);
      end else begin
        want = result_queue.pop_front();
        if (out_data.value !== want.value) begin
          errors++;
          $display("%0t: value expected %0d actual %0d", $time, want.value, out_data.value);
        end
        if (out_data.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data.status);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    string e;
    iee_pkg::in_item_t it;
    int total;
    clear_state();
    add_expr("1+2*3");
    add_expr("(1+2)*3");
    add_expr("7-3-2");
    add_expr("100/7/2");
    add_expr("-7");
    add_expr("0-7/2");
    add_expr("9223372036854775807+1");
    add_expr("18446744073709551616");
    add_expr("(0-9223372036854775807-1)/(0-1)");
    add_expr("5/0");
    add_expr("5/(3-3)+1");
    add_expr("1 2");
    add_expr("2(3)");
    add_expr("(1+2");
    add_expr("1+2)");
    add_expr("1+");
    add_expr("*");
    add_expr("((((((((((((((((((1))))))))))))))))))");
    add_expr("1+2*3+4*5+6*7+8*9+1-2-3*4/5-(6+7*(8-9*(1+2*(3-4*(5+6*(7-8*(9+1*(2+3*(4+5*(6-7*8))))))))))");
    add_expr("1 2 3a4");
    add_expr("()");
    // a run of raw character codes, and a bare last flag
    for (int c = 0; c < 48; c++) begin
      it.ch = 8'($urandom_range(0, 255)); it.last = 1'b0; char_queue.push_back(it);
    end
    it.ch = 8'hff; it.last = 1'b1; char_queue.push_back(it);
    add_expr("12*34");
    total = 0;
    while (total < 210) begin
      e = rand_expr(3);
      if ($urandom_range(0, 4) == 0) e = mangle(e);
      total += e.len();
      add_expr(e);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (char_queue.size() < 300);
    calm = 1'b1;
    wait (char_queue.size() < 150);
    calm = 1'b0;
    wait (char_queue.size() == 0 && !in_valid);
    wait (result_queue.size() == 0);
    repeat (200) @(posedge clk);
    $display("Checked %0d results from %0d characters (ok %0d, div0 %0d, overflow %0d,",
             n_results, n_chars, status_seen[0], status_seen[1], status_seen[2]);
    $display("malformed %0d), with random gaps and output stalls.", status_seen[3]);
    if (errors == 0 && result_queue.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
